// File: src/qbin_pkg.sv
// ----------------------------------------------------------------------------
// qbin_pkg
// shared types, widths and codes for the column quantile binner
// ----------------------------------------------------------------------------
`default_nettype none

package qbin_pkg;

    localparam int MAX_ROWS_DEF = 64;   // default column depth
    localparam int VAL_W        = 32;   // cell value width
    localparam int RIDX_W       = 6;    // row index field width
    localparam int CW           = 7;    // row counters, parts, bins
    localparam int DVD_W        = 14;   // scaled bin boundary and dividend
    localparam int DVS_W        = 7;    // divisor (effective parts)
    localparam logic [CW-1:0] PARTS_RESET = 7'd4;

    typedef struct packed {
        logic signed [VAL_W-1:0] value;
        logic                    last;
    } item_t;

    typedef struct packed {
        logic [RIDX_W-1:0] row_index;
        logic [CW-1:0]     bin;
        logic              keep;
        logic              end_of_column;
    } result_t;

    typedef enum logic [1:0] {
        DS_LASTB,   // n*(p-1)/p, one less than the last row that may open a bin
        DS_FIRST,   // n/p, one past the first boundary position
        DS_BOUND    // scaled boundary / p after a bin change
    } div_sel_t;

    typedef enum logic [4:0] {
        ST_LOAD,
        ST_RK_RD,
        ST_RK_LAT,
        ST_SC_RD,
        ST_SC_CMP,
        ST_RK_WR,
        ST_SETUP,
        ST_LB_DIV,
        ST_LB_WAIT,
        ST_Q0_DIV,
        ST_Q0_WAIT,
        ST_QV_RD,
        ST_QV_LAT,
        ST_EM_RD,
        ST_EM_CHK,
        ST_UP,
        ST_UP_DIV,
        ST_UP_WAIT,
        ST_UQ_RD,
        ST_UQ_LAT,
        ST_PUT,
        ST_WAIT
    } state_t;

    typedef struct packed {
        logic     load_ok;
        logic     rd_val_i;
        logic     lat_vi;
        logic     rd_val_j;
        logic     scan_cmp;
        logic     rank_wr;
        logic     setup;
        logic     div_start;
        div_sel_t div_sel;
        logic     lat_lb;
        logic     lat_q;
        logic     rd_sorted_q;
        logic     lat_qv;
        logic     rd_row;
        logic     bump;
        logic     put;
        logic     next_row;
    } cmd_t;

    typedef struct packed {
        logic last_acc;
        logic i_last;
        logic j_last;
        logic r_last;
        logic keep_now;
        logic keep;
        logic bump;
        logic div_busy;
        logic result_taken;
    } status_t;

endpackage

`default_nettype wire

// File: src/column_quantile_binner.sv
// ----------------------------------------------------------------------------
// column_quantile_binner
// loads a column, sorts it stably and reports each row's quantile bin
// ----------------------------------------------------------------------------
// A column is loaded one value per cycle; the transaction with last set
// closes it (values past MAX_ROWS are dropped, the closing flag still
// counts). Input stall then stays high until the final result transaction.
// The rows are ranked by a compare scan over the value store. The walk
// then reads each row from the sorted store and waits for the output;
// each bin change adds a boundary division on the one-bit-per-cycle
// divider, and with two or more effective parts setup runs two
// divisions. Results come in ascending value order, ties in load order.
// With fewer than two effective parts every row has keep set and bin
// zero. num_parts should be written only while no column is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module column_quantile_binner
    import qbin_pkg::*;
#(
    parameter int MAX_ROWS = MAX_ROWS_DEF
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    // input column transactions
    input  wire item_t         item,
    input  wire logic          item_valid,
    output logic               item_stall,
    // result transactions
    output result_t            result,
    output logic               result_valid,
    input  wire logic          result_stall,
    // num_parts register write
    input  wire logic          cfg_we,
    input  wire logic [CW-1:0] cfg_wdata
);

    cmd_t    cmd;
    status_t status;

    // sequencer
    qbin_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .cmd    (cmd)
    );

    // stores, counters, divider and output register
    qbin_datapath #(
        .MAX_ROWS (MAX_ROWS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .result       (result),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .cmd          (cmd),
        .status       (status)
    );

endmodule

`default_nettype wire

// File: src/qbin_div.sv
// ----------------------------------------------------------------------------
// qbin_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module qbin_div
    import qbin_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [DVD_W-1:0] dividend,
    input  wire logic [DVS_W-1:0] divisor,
    output logic                  busy,
    output logic [DVD_W-1:0]      quotient
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [DVD_W-1:0] quot_reg;
    logic [DVS_W-1:0] rem_reg;
    logic [DVS_W-1:0] dvs_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic [DVS_W:0]   rem_sh;
    logic [DVS_W:0]   diff;
    logic             ge;

    assign rem_sh = {rem_reg, quot_reg[DVD_W-1]};
    assign ge     = rem_sh >= {1'b0, dvs_reg};
    assign diff   = rem_sh - {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(DVD_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
                busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quot_reg <= dividend;
            rem_reg  <= '0;
            dvs_reg  <= divisor;
        end
        else if (busy_reg)
        begin
            quot_reg <= {quot_reg[DVD_W-2:0], ge};
            rem_reg  <= ge ? diff[DVS_W-1:0] : rem_sh[DVS_W-1:0];
        end
    end

    assign busy     = busy_reg;
    assign quotient = quot_reg;

endmodule

`default_nettype wire

// File: src/qbin_datapath.sv
// ----------------------------------------------------------------------------
// qbin_datapath
// value, order and sorted stores, rank counter, bin walk registers
// ----------------------------------------------------------------------------
`default_nettype none

module qbin_datapath
    import qbin_pkg::*;
#(
    parameter int MAX_ROWS = MAX_ROWS_DEF
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire item_t         item,
    input  wire logic          item_valid,
    output logic               item_stall,
    output result_t            result,
    output logic               result_valid,
    input  wire logic          result_stall,
    input  wire logic          cfg_we,
    input  wire logic [CW-1:0] cfg_wdata,
    input  wire cmd_t          cmd,
    output status_t            status
);

    localparam int AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

    logic signed [VAL_W-1:0] value_mem  [MAX_ROWS];
    logic signed [VAL_W-1:0] sorted_mem [MAX_ROWS];
    logic [RIDX_W-1:0]       order_mem  [MAX_ROWS];

    logic [CW-1:0]    parts_cfg_reg;
    logic [CW-1:0]    row_count_reg;
    logic [CW-1:0]    n_reg;
    logic [CW-1:0]    i_reg;
    logic [CW-1:0]    j_reg;
    logic [CW-1:0]    rank_reg;
    logic [CW-1:0]    r_reg;
    logic [CW-1:0]    q_reg;
    logic [CW-1:0]    lastb_reg;
    logic [CW-1:0]    p_reg;
    logic [CW-1:0]    bin_reg;
    logic             keep_reg;
    logic [DVD_W-1:0] bsc_reg;
    logic             result_valid_reg;
    result_t          result_reg;

    logic signed [VAL_W-1:0] vi_reg;
    logic signed [VAL_W-1:0] qv_reg;
    logic signed [VAL_W-1:0] vrd_reg;
    logic signed [VAL_W-1:0] srd_reg;
    logic [RIDX_W-1:0]       ord_reg;

    logic             item_acc;
    logic             room;
    logic [CW-1:0]    n_load;
    logic [CW-1:0]    p_now;
    logic [DVD_W-1:0] dividend;
    logic [DVD_W-1:0] quotient;
    logic             div_busy;
    logic [DVD_W-1:0] rp;
    logic [DVD_W-1:0] bmax;
    logic [DVD_W-1:0] qm1;
    logic [DVD_W-1:0] nm1;
    logic [DVD_W-1:0] qc;
    logic             ranks_first;
    logic             taken;

    assign item_acc   = item_valid & cmd.load_ok;
    assign item_stall = ~cmd.load_ok;
    assign room       = row_count_reg < CW'(MAX_ROWS);
    assign n_load     = room ? row_count_reg + 1'b1 : row_count_reg;
    assign p_now      = (parts_cfg_reg > n_reg) ? n_reg : parts_cfg_reg;
    assign taken      = result_valid_reg & ~result_stall;

    // stable order: earlier rows with an equal value rank first
    assign ranks_first = (vrd_reg < vi_reg) || ((vrd_reg == vi_reg) && (j_reg < i_reg));

    always_comb
    begin
        unique case (cmd.div_sel)
            DS_LASTB: dividend = DVD_W'(n_reg) * DVD_W'(p_reg - 1'b1);
            DS_FIRST: dividend = DVD_W'(n_reg);
            DS_BOUND: dividend = bsc_reg;
            default:  dividend = bsc_reg;
        endcase
    end

    assign rp   = DVD_W'(r_reg) * DVD_W'(p_reg);
    assign bmax = (rp > bsc_reg) ? rp : bsc_reg;
    assign qm1  = (quotient == '0) ? '0 : quotient - 1'b1;
    assign nm1  = DVD_W'(n_reg) - 1'b1;
    assign qc   = (qm1 > nm1) ? nm1 : qm1;

    qbin_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (dividend),
        .divisor  (p_reg),
        .busy     (div_busy),
        .quotient (quotient)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            parts_cfg_reg    <= PARTS_RESET;
            row_count_reg    <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                parts_cfg_reg <= cfg_wdata;
            if (item_acc)
                row_count_reg <= item.last ? '0 : n_load;
            if (cmd.put)
                result_valid_reg <= 1'b1;
            else if (taken)
                result_valid_reg <= 1'b0;
        end
    end

    // stores
    always_ff @(posedge clk)
    begin
        if (item_acc && room)
            value_mem[row_count_reg[AW-1:0]] <= item.value;
        if (cmd.rd_val_i || cmd.rd_val_j)
            vrd_reg <= value_mem[cmd.rd_val_i ? i_reg[AW-1:0] : j_reg[AW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rank_wr)
        begin
            sorted_mem[rank_reg[AW-1:0]] <= vi_reg;
            order_mem[rank_reg[AW-1:0]]  <= RIDX_W'(i_reg);
        end
        if (cmd.rd_row || cmd.rd_sorted_q)
            srd_reg <= sorted_mem[cmd.rd_row ? r_reg[AW-1:0] : q_reg[AW-1:0]];
        if (cmd.rd_row)
            ord_reg <= order_mem[r_reg[AW-1:0]];
    end

    // sort and walk registers
    always_ff @(posedge clk)
    begin
        if (item_acc && item.last)
        begin
            n_reg <= n_load;
            i_reg <= '0;
        end
        if (cmd.lat_vi)
        begin
            vi_reg   <= vrd_reg;
            j_reg    <= '0;
            rank_reg <= '0;
        end
        if (cmd.scan_cmp)
        begin
            j_reg <= j_reg + 1'b1;
            if (ranks_first)
                rank_reg <= rank_reg + 1'b1;
        end
        if (cmd.rank_wr)
            i_reg <= i_reg + 1'b1;
        if (cmd.setup)
        begin
            p_reg    <= p_now;
            keep_reg <= p_now < CW'(2);
            bin_reg  <= CW'(1);
            bsc_reg  <= DVD_W'(n_reg);
            r_reg    <= '0;
        end
        if (cmd.lat_lb)
            lastb_reg <= quotient[CW-1:0] + 1'b1;
        if (cmd.lat_q)
            q_reg <= qc[CW-1:0];
        if (cmd.lat_qv)
            qv_reg <= srd_reg;
        if (cmd.bump)
        begin
            bin_reg <= bin_reg + 1'b1;
            bsc_reg <= bmax + DVD_W'(n_reg);
        end
        if (cmd.next_row)
            r_reg <= r_reg + 1'b1;
        if (cmd.put)
        begin
            result_reg.row_index     <= ord_reg;
            result_reg.bin           <= keep_reg ? '0 : bin_reg;
            result_reg.keep          <= keep_reg;
            result_reg.end_of_column <= r_reg == n_reg - 1'b1;
        end
    end

    assign status.last_acc     = item_acc & item.last;
    assign status.i_last       = i_reg == n_reg - 1'b1;
    assign status.j_last       = j_reg == n_reg - 1'b1;
    assign status.r_last       = r_reg == n_reg - 1'b1;
    assign status.keep_now     = p_now < CW'(2);
    assign status.keep         = keep_reg;
    assign status.bump         = (srd_reg > qv_reg) && (r_reg <= lastb_reg);
    assign status.div_busy     = div_busy;
    assign status.result_taken = taken;

    assign result       = result_reg;
    assign result_valid = result_valid_reg;

    a_rank_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rank_wr |-> rank_reg < n_reg)
        else $error("rank beyond row count");

    a_div_idle_at_start: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |-> !div_busy)
        else $error("divider started while busy");

    a_put_into_empty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.put |-> !result_valid_reg)
        else $error("result register overwritten");

    a_boundary_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.lat_q |=> q_reg < n_reg)
        else $error("boundary position beyond row count");

endmodule

`default_nettype wire

// File: src/qbin_ctrl.sv
// ----------------------------------------------------------------------------
// qbin_ctrl
// sequencer for load, rank sort, boundary setup and bin walk
// ----------------------------------------------------------------------------
`default_nettype none

module qbin_ctrl
    import qbin_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire status_t status,
    output cmd_t         cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_LOAD;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD:    if (status.last_acc) state_next = ST_RK_RD;
            ST_RK_RD:   state_next = ST_RK_LAT;
            ST_RK_LAT:  state_next = ST_SC_RD;
            ST_SC_RD:   state_next = ST_SC_CMP;
            ST_SC_CMP:  state_next = status.j_last ? ST_RK_WR : ST_SC_RD;
            ST_RK_WR:   state_next = status.i_last ? ST_SETUP : ST_RK_RD;
            ST_SETUP:   state_next = status.keep_now ? ST_EM_RD : ST_LB_DIV;
            ST_LB_DIV:  state_next = ST_LB_WAIT;
            ST_LB_WAIT: if (!status.div_busy) state_next = ST_Q0_DIV;
            ST_Q0_DIV:  state_next = ST_Q0_WAIT;
            ST_Q0_WAIT: if (!status.div_busy) state_next = ST_QV_RD;
            ST_QV_RD:   state_next = ST_QV_LAT;
            ST_QV_LAT:  state_next = ST_EM_RD;
            ST_EM_RD:   state_next = ST_EM_CHK;
            ST_EM_CHK:  state_next = (status.bump && !status.keep) ? ST_UP : ST_PUT;
            ST_UP:      state_next = ST_UP_DIV;
            ST_UP_DIV:  state_next = ST_UP_WAIT;
            ST_UP_WAIT: if (!status.div_busy) state_next = ST_UQ_RD;
            ST_UQ_RD:   state_next = ST_UQ_LAT;
            ST_UQ_LAT:  state_next = ST_PUT;
            ST_PUT:     state_next = ST_WAIT;
            ST_WAIT:
            begin
                if (status.result_taken)
                    state_next = status.r_last ? ST_LOAD : ST_EM_RD;
            end
            default:    state_next = ST_LOAD;
        endcase
    end

    always_comb
    begin
        cmd         = '0;
        cmd.div_sel = DS_BOUND;
        unique case (state_reg)
            ST_LOAD:    cmd.load_ok = 1'b1;
            ST_RK_RD:   cmd.rd_val_i = 1'b1;
            ST_RK_LAT:  cmd.lat_vi = 1'b1;
            ST_SC_RD:   cmd.rd_val_j = 1'b1;
            ST_SC_CMP:  cmd.scan_cmp = 1'b1;
            ST_RK_WR:   cmd.rank_wr = 1'b1;
            ST_SETUP:   cmd.setup = 1'b1;
            ST_LB_DIV:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DS_LASTB;
            end
            ST_LB_WAIT: cmd.lat_lb = ~status.div_busy;
            ST_Q0_DIV:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DS_FIRST;
            end
            ST_Q0_WAIT: cmd.lat_q = ~status.div_busy;
            ST_QV_RD:   cmd.rd_sorted_q = 1'b1;
            ST_QV_LAT:  cmd.lat_qv = 1'b1;
            ST_EM_RD:   cmd.rd_row = 1'b1;
            ST_EM_CHK:  cmd.div_sel = DS_BOUND;
            ST_UP:      cmd.bump = 1'b1;
            ST_UP_DIV:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DS_BOUND;
            end
            ST_UP_WAIT: cmd.lat_q = ~status.div_busy;
            ST_UQ_RD:   cmd.rd_sorted_q = 1'b1;
            ST_UQ_LAT:  cmd.lat_qv = 1'b1;
            ST_PUT:     cmd.put = 1'b1;
            ST_WAIT:    cmd.next_row = status.result_taken & ~status.r_last;
            default:    cmd = '0;
        endcase
    end

endmodule

`default_nettype wire

// File: tb/column_quantile_binner_test.sv
// ----------------------------------------------------------------------------
// column_quantile_binner_test
// checks sorted row order and quantile bins of the column quantile binner
// ----------------------------------------------------------------------------
// Columns are loaded through the item channel. A column model predicts the
// stable sort and bin walk when the closing transaction is accepted, and the
// scoreboard compares each result transaction with the oldest prediction.
// num_parts is changed between columns, once the block is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module column_quantile_binner_test;
    import qbin_pkg::*;

    localparam int WATCHDOG_LIMIT = 200000;

    // column model and store of predicted results
    class bin_scoreboard;
        logic signed [VAL_W-1:0] column_vals[$];
        logic [CW-1:0]           parts_reg;
        result_t                 pending[$];
        int                      errors;

        function new();
            parts_reg = PARTS_RESET;
            errors = 0;
        endfunction

        // bin walk over one closed column
        function void close_column();
            int n, p, bsc, q, lastb, quant;
            int order[$];
            logic signed [VAL_W-1:0] qv;
            result_t res;
            n = column_vals.size();
            // stable ranking: ascending, ties in load order
            for (int i = 0; i < n; i++)
            begin
                int j;
                j = 0;
                while (j < order.size() && column_vals[order[j]] <= column_vals[i])
                    j++;
                order.insert(j, i);
            end
            p = (parts_reg > n) ? n : parts_reg;
            quant = 1;
            bsc = n;
            lastb = 0;
            if (p >= 2)
            begin
                qv = column_vals[order[bsc / p - 1]];
                lastb = (n * (p - 1)) / p + 1;
            end
            for (int r = 0; r < n; r++)
            begin
                res.row_index = RIDX_W'(order[r]);
                res.end_of_column = (r == n - 1);
                if (p < 2)
                begin
                    res.bin = '0;
                    res.keep = 1'b1;
                end
                else
                begin
                    if (column_vals[order[r]] > qv && r <= lastb)
                    begin
                        quant++;
                        if (r * p > bsc)
                            bsc = r * p;
                        bsc += n;
                        q = bsc / p;
                        q = (q == 0) ? 0 : q - 1;
                        if (q > n - 1)
                            q = n - 1;
                        qv = column_vals[order[q]];
                    end
                    res.bin = CW'(quant);
                    res.keep = 1'b0;
                end
                pending.push_back(res);
            end
            column_vals.delete();
        endfunction

        function void note_item(item_t it);
            if (column_vals.size() < MAX_ROWS_DEF)
                column_vals.push_back(it.value);
            if (it.last)
                close_column();
        endfunction

        task check_result(result_t got);
            result_t want;
            if (pending.size() == 0)
            begin
                report_mismatch("result with no prediction", got, got);
                return;
            end
            want = pending.pop_front();
            if (got.row_index !== want.row_index)
                report_mismatch("row_index", got, want);
            if (got.bin !== want.bin)
                report_mismatch("bin", got, want);
            if (got.keep !== want.keep)
                report_mismatch("keep", got, want);
            if (got.end_of_column !== want.end_of_column)
                report_mismatch("end_of_column", got, want);
        endtask

        task report_mismatch(string what, result_t got, result_t want);
            errors++;
            $display({"mismatch %s: got row %0d bin %0d keep %0b eoc %0b, ",
                      "want row %0d bin %0d keep %0b eoc %0b"},
                     what, got.row_index, got.bin, got.keep, got.end_of_column,
                     want.row_index, want.bin, want.keep, want.end_of_column);
        endtask
    endclass

    logic    clk;
    logic    rst_n;
    item_t   item;
    logic    item_valid;
    logic    item_stall;
    result_t result;
    logic    result_valid;
    logic    result_stall;
    logic    cfg_we;
    logic [CW-1:0] cfg_wdata;

    bin_scoreboard sb;
    int  send_idle_pct;
    int  recv_idle_pct;
    int  quiet_cycles;
    int  items_sent;

    column_quantile_binner dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .result       (result),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // accepted transactions are sampled at the rising edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (item_valid && !item_stall)
                sb.note_item(item);
            if (result_valid && !result_stall)
                sb.check_result(result);
        end
    end

    // watchdog on cycles with no transaction at all
    always @(posedge clk)
    begin
        if ((item_valid && !item_stall) || (result_valid && !result_stall) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // receiver stall, redrawn at each falling edge
    always @(negedge clk)
        result_stall <= ($urandom_range(99) < recv_idle_pct);

    // one item transaction; valid stays high if the next item follows at once
    task automatic send_item(input logic signed [VAL_W-1:0] v, input logic lst);
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            item <= '{value: $urandom, last: $urandom_range(1)};
            @(negedge clk);
        end
        item_valid <= 1'b1;
        item <= '{value: v, last: lst};
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        @(negedge clk);
        items_sent++;
    endtask

    // wait for all results, plus slack for an unfinished column
    task automatic drain();
        item_valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    task automatic write_parts(input logic [CW-1:0] p);
        drain();
        cfg_we <= 1'b1;
        cfg_wdata <= p;
        @(negedge clk);
        cfg_we <= 1'b0;
        sb.parts_reg = p;
    endtask

    function automatic logic signed [VAL_W-1:0] pick_value(input int mode);
        case (mode)
            0: return $urandom;
            1: return $signed($urandom_range(7)) - 3;    // many ties
            2: return ($urandom_range(1) ? 32'sh7fffffff : 32'sh80000000);
            default: return $signed($urandom_range(40)) - 20;
        endcase
    endfunction

    // one column of n rows with random content
    task automatic send_column(input int n, input int mode);
        for (int i = 0; i < n; i++)
            send_item(pick_value(mode), i == n - 1);
    endtask

    task automatic random_phase(input int s_pct, input int r_pct, input int n_items);
        int target;
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        target = items_sent + n_items;
        while (items_sent < target)
        begin
            if ($urandom_range(5) == 0)
                write_parts(CW'($urandom_range(0, 70)));
            send_column($urandom_range(9) == 0 ? $urandom_range(20, 64)
                                              : $urandom_range(1, 10),
                        $urandom_range(3));
        end
    endtask

    initial
    begin
        sb = new();
        rst_n = 1'b0;
        item = '0;
        item_valid = 1'b0;
        result_stall = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        quiet_cycles = 0;
        items_sent = 0;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: reset parts, extremes, one-row column, ties, overflow
        send_item(32'sh7fffffff, 1'b0);
        send_item(32'sh80000000, 1'b0);
        send_item(32'sh0, 1'b0);
        send_item(32'shffffffff, 1'b1);
        send_item(32'sd5, 1'b1);
        write_parts(7'd0);
        send_item(32'sd3, 1'b0);
        send_item(32'sd3, 1'b1);
        write_parts(7'd1);
        send_item(-32'sd9, 1'b0);
        send_item(32'sd9, 1'b1);
        write_parts(7'd64);
        send_item(32'sd2, 1'b0);
        send_item(32'sd2, 1'b0);
        send_item(32'sd1, 1'b1);
        write_parts(7'd127);
        send_item(32'sd7, 1'b0);
        send_item(32'sd4, 1'b1);
        write_parts(7'd3);
        send_column(66, 0);          // two rows dropped, store full at close
        write_parts(7'd2);
        send_column(5, 1);

        random_phase(19, 59, 130);
        random_phase(59, 19, 130);
        random_phase(0, 0, 120);
        drain();

        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
